### hw/rtl/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types and fixed tables of the character reference decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

  localparam int NUM_NAMES = 38;
  localparam logic [20:0] CP_MAX = 21'h10FFFF;
  localparam logic [20:0] CP_OVER = 21'h110000;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        final_byte;
    logic [15:0] decoded_total;
  } out_item_t;

  typedef struct packed {
    logic        final_byte;
    logic [15:0] decoded_total;
  } job_tail_t;

  // names are right-justified: first character in the highest used byte
  localparam logic [47:0] NAME_TAB [NUM_NAMES] = '{
    48'("amp"), 48'("lt"), 48'("gt"), 48'("quot"), 48'("apos"),
    48'("nbsp"), 48'("copy"), 48'("reg"), 48'("trade"), 48'("euro"),
    48'("pound"), 48'("yen"), 48'("cent"), 48'("deg"), 48'("plusmn"),
    48'("times"), 48'("divide"), 48'("sect"), 48'("para"), 48'("middot"),
    48'("mdash"), 48'("ndash"), 48'("lsquo"), 48'("rsquo"), 48'("ldquo"),
    48'("rdquo"), 48'("hellip"), 48'("laquo"), 48'("raquo"), 48'("alpha"),
    48'("beta"), 48'("gamma"), 48'("delta"), 48'("infin"), 48'("ne"),
    48'("le"), 48'("ge"), 48'("check")
  };

  localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{
    3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd5, 3'd4,
    3'd5, 3'd3, 3'd4, 3'd3, 3'd6, 3'd5, 3'd6, 3'd4, 3'd4, 3'd6,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd5, 3'd5, 3'd5,
    3'd4, 3'd5, 3'd5, 3'd5, 3'd2, 3'd2, 3'd2, 3'd5
  };

  localparam logic [1:0] CODE_LEN [NUM_NAMES] = '{
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3
  };

  localparam logic [23:0] CODE_TAB [NUM_NAMES] = '{
    24'h260000, 24'h3C0000, 24'h3E0000, 24'h220000, 24'h270000,
    24'hC2A000, 24'hC2A900, 24'hC2AE00, 24'hE284A2, 24'hE282AC,
    24'hC2A300, 24'hC2A500, 24'hC2A200, 24'hC2B000, 24'hC2B100,
    24'hC39700, 24'hC3B700, 24'hC2A700, 24'hC2B600, 24'hC2B700,
    24'hE28094, 24'hE28093, 24'hE28098, 24'hE28099, 24'hE2809C,
    24'hE2809D, 24'hE280A6, 24'hC2AB00, 24'hC2BB00, 24'hCEB100,
    24'hCEB200, 24'hCEB300, 24'hCEB400, 24'hE2889E, 24'hE289A0,
    24'hE289A4, 24'hE289A5, 24'hE29C93
  };

endpackage

### hw/rtl/hed_front.sv
// ----------------------------------------------------------------------------
// hed_front
// Accepts text bytes, tracks an open reference and turns each byte into one
// job: the full list of output bytes it causes.
// ----------------------------------------------------------------------------
module hed_front #(
  parameter int SCAN_WINDOW = 12,
  parameter int COUNT_BITS  = 16,
  parameter int SEQ_N       = SCAN_WINDOW + 1,
  parameter int LEN_W       = $clog2(SEQ_N + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  hed_pkg::in_item_t        in_data,
  input  logic                     q_full,
  output logic                     job_push,
  output logic [SEQ_N-1:0][7:0]    job_seq,
  output logic [LEN_W-1:0]         job_len,
  output hed_pkg::job_tail_t       job_tail
);
  import hed_pkg::*;

  localparam int NAME_MAX = SCAN_WINDOW - 1;
  localparam int HC_W     = $clog2(SCAN_WINDOW);
  localparam int HI_W     = $clog2(NAME_MAX);

  typedef enum logic [2:0] {
    P_HASH, P_XOPT, P_WS, P_PRE, P_ZERO, P_DIG, P_DONE, P_NAME
  } parse_t;

  logic                  in_ref_r, in_ref_nxt;
  logic [HC_W-1:0]       hcnt_r, hcnt_nxt;
  logic [7:0]            held_r [NAME_MAX];
  logic [7:0]            held_wr [NAME_MAX];
  parse_t                pst_r, pst_nxt;
  logic                  hex_r, hex_nxt;
  logic                  neg_r, neg_nxt;
  logic [20:0]           val_r, val_nxt;
  logic [NUM_NAMES-1:0]  mask_r, mask_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_after;

  logic [7:0] b;
  logic       eot, accept, holdable, closing, ok, flush, fresh, opening, tail;
  logic       dec_ok, name_hit, is_x, is_ws, is_dig;
  logic [3:0] dval;
  logic [23:0] name_code;
  logic [1:0]  name_clen;
  logic [31:0] code;
  logic [2:0]  clen;
  logic [HC_W:0]  hcnt_eff;
  logic [LEN_W-1:0] head_len;
  logic [NUM_NAMES-1:0] len_match;
  logic [31:0] c32;

  assign b        = in_data.text_byte;
  assign eot      = in_data.end_of_text;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign is_x  = (b == "x") || (b == "X");
  assign is_ws = ((b >= 8'h09) && (b <= 8'h0D)) || (b == 8'h20);

  always_comb begin
    is_dig = 1'b0;
    dval   = 4'd0;
    if ((b >= "0") && (b <= "9")) begin
      is_dig = 1'b1;
      dval   = 4'(b - "0");
    end else if (hex_r && (b >= "a") && (b <= "f")) begin
      is_dig = 1'b1;
      dval   = 4'(b - "a" + 8'd10);
    end else if (hex_r && (b >= "A") && (b <= "F")) begin
      is_dig = 1'b1;
      dval   = 4'(b - "A" + 8'd10);
    end
  end

  // name match over the held prefix
  always_comb begin
    logic [2:0] idx;
    logic [7:0] ch;
    name_code = '0;
    name_clen = '0;
    for (int k = 0; k < NUM_NAMES; k++) begin
      idx = 3'd0;
      ch  = 8'd0;
      len_match[k] = (32'(NAME_LEN[k]) == 32'(hcnt_r));
      if (32'(hcnt_r) < 32'(NAME_LEN[k])) begin
        idx = 3'(32'(NAME_LEN[k]) - 32'(hcnt_r) - 32'd1);
        ch  = NAME_TAB[k][8*idx +: 8];
      end
      mask_nxt[k] = mask_r[k] && (32'(hcnt_r) < 32'(NAME_LEN[k])) && (ch == b);
      if (mask_r[k] && len_match[k]) begin
        name_code = name_code | CODE_TAB[k];
        name_clen = name_clen | CODE_LEN[k];
      end
    end
  end
  assign name_hit = |(mask_r & len_match);

  // one numeric parse step on a held byte
  always_comb begin
    parse_t     s;
    logic       used;
    logic [25:0] acc;
    s       = pst_r;
    used    = 1'b0;
    hex_nxt = hex_r;
    neg_nxt = neg_r;
    val_nxt = val_r;
    pst_nxt = pst_r;
    acc     = '0;
    if (s == P_HASH) begin
      pst_nxt = (b == "#") ? P_XOPT : P_NAME;
      used    = 1'b1;
    end
    if (!used && (s == P_XOPT)) begin
      if (is_x) begin
        hex_nxt = 1'b1;
        pst_nxt = P_WS;
        used    = 1'b1;
      end else begin
        s = P_WS;
      end
    end
    if (!used && (s == P_WS)) begin
      if (is_ws) begin
        pst_nxt = P_WS;
        used    = 1'b1;
      end else if ((b == "+") || (b == "-")) begin
        neg_nxt = (b == "-");
        pst_nxt = hex_nxt ? P_PRE : P_DIG;
        used    = 1'b1;
      end else begin
        s = hex_nxt ? P_PRE : P_DIG;
      end
    end
    if (!used && (s == P_PRE)) begin
      if (b == "0") begin
        pst_nxt = P_ZERO;
        used    = 1'b1;
      end else begin
        s = P_DIG;
      end
    end
    if (!used && (s == P_ZERO)) begin
      if (is_x) begin
        pst_nxt = P_DIG;
        used    = 1'b1;
      end else begin
        s = P_DIG;
      end
    end
    if (!used && (s == P_DIG)) begin
      if (is_dig) begin
        acc = hex_nxt ? {1'b0, val_r, 4'b0} : 26'(val_r) * 26'd10;
        acc = acc + 26'(dval);
        val_nxt = (acc > 26'(CP_MAX)) ? CP_OVER : acc[20:0];
        pst_nxt = P_DIG;
      end else begin
        pst_nxt = P_DONE;
      end
    end
  end

  always_comb begin
    dec_ok = 1'b0;
    unique case (pst_r)
      P_HASH:  dec_ok = 1'b0;
      P_NAME:  dec_ok = name_hit;
      default: dec_ok = !neg_r && (val_r != 21'd0) && (val_r <= CP_MAX);
    endcase
  end

  // UTF-8 code of the closed reference
  always_comb begin
    code = '0;
    clen = 3'd0;
    if (pst_r == P_NAME) begin
      code = {name_code, 8'h00};
      clen = {1'b0, name_clen};
    end else if (val_r <= 21'h7F) begin
      code = {val_r[7:0], 24'h0};
      clen = 3'd1;
    end else if (val_r <= 21'h7FF) begin
      code = {8'hC0 | {3'b0, val_r[10:6]}, 8'h80 | {2'b0, val_r[5:0]}, 16'h0};
      clen = 3'd2;
    end else if (val_r <= 21'hFFFF) begin
      code = {8'hE0 | {4'b0, val_r[15:12]}, 8'h80 | {2'b0, val_r[11:6]},
              8'h80 | {2'b0, val_r[5:0]}, 8'h0};
      clen = 3'd3;
    end else begin
      code = {8'hF0 | {5'b0, val_r[20:18]}, 8'h80 | {2'b0, val_r[17:12]},
              8'h80 | {2'b0, val_r[11:6]}, 8'h80 | {2'b0, val_r[5:0]}};
      clen = 3'd4;
    end
  end

  assign holdable = in_ref_r && (32'(hcnt_r) < NAME_MAX) &&
                    (b != ";") && (b != " ") && (b != "&");
  assign closing  = in_ref_r && !holdable;
  assign ok       = closing && (b == ";") && dec_ok;
  assign fresh    = !in_ref_r || (closing && !ok);
  assign flush    = (closing && !ok) || (holdable && eot);
  assign opening  = fresh && (b == "&");
  assign tail     = fresh && ((b != "&") || eot);
  assign hcnt_eff = holdable ? ({1'b0, hcnt_r} + 1'b1) : {1'b0, hcnt_r};

  always_comb begin
    for (int k = 0; k < NAME_MAX; k++) begin
      held_wr[k] = (holdable && (32'(hcnt_r) == k)) ? b : held_r[k];
    end
  end

  always_comb begin
    logic [7:0] h;
    head_len = flush ? LEN_W'(hcnt_eff) + 1'b1 : (ok ? LEN_W'(clen) : '0);
    for (int j = 0; j < SEQ_N; j++) begin
      h = 8'h00;
      if (flush) begin
        if (j == 0) begin
          h = "&";
        end else if (j <= NAME_MAX) begin
          h = held_wr[j-1];
        end
      end else if (j < 4) begin
        h = code[8*(3-j) +: 8];
      end
      job_seq[j] = (32'(j) < 32'(head_len)) ? h : b;
    end
    job_len = head_len + LEN_W'(tail);
  end

  always_comb begin
    cnt_after = cnt_r;
    if (ok && (cnt_r != '1)) begin
      cnt_after = cnt_r + 1'b1;
    end
    cnt_nxt = eot ? '0 : cnt_after;
    c32 = 32'(cnt_after);
    job_tail.final_byte    = eot;
    job_tail.decoded_total = (c32 > 32'hFFFF) ? 16'hFFFF : c32[15:0];
  end

  assign job_push   = accept && (job_len != '0);
  assign in_ref_nxt = !eot && (holdable || opening);
  assign hcnt_nxt   = (holdable && !eot) ? hcnt_r + 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ref_r <= 1'b0;
      hcnt_r   <= '0;
      cnt_r    <= '0;
      pst_r    <= P_HASH;
    end else if (accept) begin
      in_ref_r <= in_ref_nxt;
      hcnt_r   <= hcnt_nxt;
      cnt_r    <= cnt_nxt;
      if (opening) begin
        pst_r <= P_HASH;
      end else if (holdable) begin
        pst_r <= pst_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (opening) begin
        mask_r <= '1;
        val_r  <= '0;
        neg_r  <= 1'b0;
        hex_r  <= 1'b0;
      end else if (holdable) begin
        mask_r <= mask_nxt;
        val_r  <= val_nxt;
        neg_r  <= neg_nxt;
        hex_r  <= hex_nxt;
        held_r[hcnt_r[HI_W-1:0]] <= b;
      end
    end
  end

endmodule

### hw/rtl/hed_queue.sv
// ----------------------------------------------------------------------------
// hed_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module hed_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (32'(cnt_r) == DEPTH);
  assign empty     = (cnt_r == '0);
  assign head_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (32'(wp_r) == DEPTH - 1) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (32'(rp_r) == DEPTH - 1) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

### hw/rtl/hed_back.sv
// ----------------------------------------------------------------------------
// hed_back
// Walks the head job into the output register one byte per unstalled beat.
// ----------------------------------------------------------------------------
module hed_back #(
  parameter int SEQ_N = 13,
  parameter int LEN_W = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  logic [SEQ_N-1:0][7:0] head_seq,
  input  logic [LEN_W-1:0]      head_len,
  input  hed_pkg::job_tail_t    head_tail,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hed_pkg::out_item_t    out_data
);
  import hed_pkg::*;

  localparam int IDX_W = $clog2(SEQ_N);

  logic [IDX_W-1:0] idx_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic             load, last;

  assign load      = !q_empty && (!out_valid_r || out_ready);
  assign last      = (32'(idx_r) + 32'd1 == 32'(head_len));
  assign q_pop     = load && last;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= last ? '0 : idx_r + 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.out_byte      <= head_seq[idx_r];
      out_data_r.final_byte    <= last && head_tail.final_byte;
      out_data_r.decoded_total <= (last && head_tail.final_byte) ?
                                  head_tail.decoded_total : 16'h0;
    end
  end

  a_total_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.final_byte |-> out_data_r.decoded_total == 16'h0)
    else $error("total shown on a non-final byte");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> 32'(idx_r) < 32'(head_len))
    else $error("byte index beyond job length");

endmodule

### hw/rtl/html_entity_decoder_core.sv
// ----------------------------------------------------------------------------
// html_entity_decoder_core
// Streaming decoder of HTML character references into UTF-8.
// ----------------------------------------------------------------------------
// The core takes one text byte per cycle as long as its job queue has room;
// each byte becomes a job of 0 to SCAN_WINDOW+1 output bytes, and the back end
// sends one output byte per cycle while out_ready is high, so a job holds the
// output side until it is sent, while the QUEUE_DEPTH-entry queue keeps the
// input moving. Text without references runs at one byte per cycle in and out;
// a text's last byte carries final_byte and the count of decoded references.
// ----------------------------------------------------------------------------
module html_entity_decoder_core #(
  parameter int SCAN_WINDOW = 12,
  parameter int COUNT_BITS  = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hed_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hed_pkg::out_item_t out_data
);
  import hed_pkg::*;

  localparam int SEQ_N = SCAN_WINDOW + 1;
  localparam int LEN_W = $clog2(SEQ_N + 1);
  localparam int JOB_W = SEQ_N * 8 + LEN_W + $bits(job_tail_t);

  logic                  q_full, q_empty, job_push, q_pop;
  logic [SEQ_N-1:0][7:0] job_seq, head_seq;
  logic [LEN_W-1:0]      job_len, head_len;
  job_tail_t             job_tail, head_tail;
  logic [JOB_W-1:0]      head_job;

  hed_front #(
    .SCAN_WINDOW (SCAN_WINDOW),
    .COUNT_BITS  (COUNT_BITS),
    .SEQ_N       (SEQ_N),
    .LEN_W       (LEN_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .job_push (job_push),
    .job_seq  (job_seq),
    .job_len  (job_len),
    .job_tail (job_tail)
  );

  hed_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data ({job_seq, job_len, job_tail}),
    .pop       (q_pop),
    .head_data (head_job),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign {head_seq, head_len, head_tail} = head_job;

  hed_back #(
    .SEQ_N (SEQ_N),
    .LEN_W (LEN_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head_seq  (head_seq),
    .head_len  (head_len),
    .head_tail (head_tail),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
